// ===== sv/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// types, constants and table lookups of the straddling checkerboard codec
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] NO_ENTRY    = 8'h00;

    localparam int unsigned NUM_COLS = 10;
    localparam int unsigned NUM_TOP  = 8;

    // operation codes carried on tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    localparam logic [3:0] KEY_LOW_RESET  = 4'd2;
    localparam logic [3:0] KEY_HIGH_RESET = 4'd6;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ROW2 = 2'd1,
        PEND_ROW3 = 2'd2
    } pend_t;

    localparam logic [7:0] TOP_LETTERS [NUM_TOP] = '{
        8'h64, 8'h65, 8'h6E, 8'h61, 8'h72, 8'h69, 8'h6F, 8'h73
    };

    localparam logic [7:0] ROW_TWO [NUM_COLS] = '{
        8'h62, 8'h63, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'hF1
    };

    localparam logic [7:0] ROW_THREE [NUM_COLS] = '{
        8'h70, 8'h71, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h23
    };

    // top-row letter at a column, or NO_ENTRY for a blank or empty column
    function automatic logic [7:0] top_entry(
        input logic [3:0] col,
        input logic [3:0] key_lo,
        input logic [3:0] key_hi
    );
        logic [3:0] j;
        logic [7:0] t;
        j = col - {3'd0, (key_lo < col)} - {3'd0, ((key_hi < col) && (key_hi != key_lo))};
        t = NO_ENTRY;
        if ((col != key_lo) && (col != key_hi) && (j < 4'(NUM_TOP))) begin
            t = TOP_LETTERS[j[2:0]];
        end
        return t;
    endfunction

    // row two entry at a digit column (digits 0..9 only)
    function automatic logic [7:0] row_two_entry(input logic [3:0] d);
        logic [7:0] t;
        t = NO_ENTRY;
        if (d < 4'(NUM_COLS)) begin
            t = ROW_TWO[d];
        end
        return t;
    endfunction

    function automatic logic [7:0] row_three_entry(input logic [3:0] d);
        logic [7:0] t;
        t = NO_ENTRY;
        if (d < 4'(NUM_COLS)) begin
            t = ROW_THREE[d];
        end
        return t;
    endfunction

endpackage

// ===== sv/straddling_checkerboard_codec.sv =====
// ----------------------------------------------------------------------------
// straddling_checkerboard_codec
// monome-binome cipher codec over a fixed 3x10 checkerboard
// ----------------------------------------------------------------------------
// A request on the slave stream carries one byte and an operation on tuser
// (0 encrypt, 1 decrypt). The byte lands in an input register; one pass of
// table logic turns it into zero, one or two result bytes, which go into a
// two-entry result register on the master stream, tlast marking the final
// byte of each request; both registers lie between accept and the first
// result. Requests that give one or no result are taken every cycle while
// m_tready is high; an encrypted letter of row two or three gives prefix
// digit plus column digit as two master beats, and the next request is
// taken only as the second digit leaves. In decrypt mode a prefix digit
// (key_low or key_high) is remembered and the following digit yields the
// letter; a space passes through and clears it. Bytes that match nothing
// give no result. The user must write key_low and key_high through the
// config port only while the codec is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module straddling_checkerboard_codec
(
    input  logic       clk,
    input  logic       rst_n,

    // config write port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,

    // request stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic       s_tuser,    // [0] op

    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic       m_tlast
);

    // keys
    logic [3:0] key_low_reg;
    logic [3:0] key_high_reg;

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_op_reg;
    logic [7:0] s1_char_reg;
    logic       s1_take;

    // decrypt prefix state
    scc_pkg::pend_t pend_reg;
    scc_pkg::pend_t pend_next;

    // result register, two slots
    logic [1:0] out_cnt_reg;
    logic [1:0] out_cnt_next;
    logic [7:0] out_d0_reg;
    logic [7:0] out_d0_next;
    logic       out_last0_reg;
    logic       out_last0_next;
    logic [7:0] out_d1_reg;
    logic [7:0] out_d1_next;
    logic       out_fire;
    logic       out_room;

    // per-request results
    logic [1:0] res_n;
    logic [7:0] res0;
    logic [7:0] res1;

    // encrypt matches
    logic       top_hit;
    logic       r2_hit;
    logic       r3_hit;
    logic [3:0] top_col;
    logic [3:0] r2_col;
    logic [3:0] r3_col;

    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] top_dec;

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= scc_pkg::KEY_LOW_RESET;
            key_high_reg <= scc_pkg::KEY_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scc_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                scc_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign out_fire = m_tvalid && m_tready;
    // result register can take a new request this cycle
    assign out_room = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_tready);
    assign s1_take  = s1_valid_reg && out_room;
    assign s_tready = !s1_valid_reg || s1_take;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_tvalid && s_tready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg   <= s_tuser;
            s1_char_reg <= s_tdata;
        end
    end

    // ---------------- encrypt lookup ----------------
    // every column is checked in parallel; the letters of the three rows are
    // all distinct so at most one row can hit
    always_comb
    begin
        top_hit = 1'b0;
        r2_hit  = 1'b0;
        r3_hit  = 1'b0;
        top_col = 4'd0;
        r2_col  = 4'd0;
        r3_col  = 4'd0;
        for (int c = 0; c < scc_pkg::NUM_COLS; c++)
        begin
            if ((scc_pkg::top_entry(4'(c), key_low_reg, key_high_reg) != scc_pkg::NO_ENTRY)
                && (scc_pkg::top_entry(4'(c), key_low_reg, key_high_reg) == s1_char_reg))
            begin
                top_hit = 1'b1;
                top_col = 4'(c);
            end
            if (scc_pkg::ROW_TWO[c] == s1_char_reg)
            begin
                r2_hit = 1'b1;
                r2_col = 4'(c);
            end
            if (scc_pkg::ROW_THREE[c] == s1_char_reg)
            begin
                r3_hit = 1'b1;
                r3_col = 4'(c);
            end
        end
    end

    // ---------------- decrypt lookup ----------------
    assign is_digit = (s1_char_reg >= scc_pkg::ASCII_ZERO) && (s1_char_reg <= scc_pkg::ASCII_NINE);
    assign digit    = s1_char_reg[3:0];
    assign top_dec  = scc_pkg::top_entry(digit, key_low_reg, key_high_reg);

    // ---------------- results ----------------
    always_comb
    begin
        res_n     = 2'd0;
        res0      = scc_pkg::ASCII_SPACE;
        res1      = scc_pkg::ASCII_SPACE;
        pend_next = pend_reg;
        if (s1_op_reg == scc_pkg::OP_ENCRYPT)
        begin
            if (s1_char_reg == scc_pkg::ASCII_SPACE)
            begin
                res_n = 2'd1;
            end
            else if (top_hit)
            begin
                res_n = 2'd1;
                res0  = scc_pkg::ASCII_ZERO + {4'd0, top_col};
            end
            else if (r2_hit)
            begin
                res_n = 2'd2;
                res0  = scc_pkg::ASCII_ZERO + {4'd0, key_low_reg};
                res1  = scc_pkg::ASCII_ZERO + {4'd0, r2_col};
            end
            else if (r3_hit)
            begin
                res_n = 2'd2;
                res0  = scc_pkg::ASCII_ZERO + {4'd0, key_high_reg};
                res1  = scc_pkg::ASCII_ZERO + {4'd0, r3_col};
            end
        end
        else
        begin
            if (s1_char_reg == scc_pkg::ASCII_SPACE)
            begin
                res_n     = 2'd1;
                pend_next = scc_pkg::PEND_NONE;
            end
            else if (is_digit)
            begin
                unique case (pend_reg)
                    scc_pkg::PEND_ROW2:
                    begin
                        res_n     = 2'd1;
                        res0      = scc_pkg::row_two_entry(digit);
                        pend_next = scc_pkg::PEND_NONE;
                    end
                    scc_pkg::PEND_ROW3:
                    begin
                        res_n     = 2'd1;
                        res0      = scc_pkg::row_three_entry(digit);
                        pend_next = scc_pkg::PEND_NONE;
                    end
                    default:
                    begin
                        // low key wins when both keys are equal
                        if (digit == key_low_reg)
                        begin
                            pend_next = scc_pkg::PEND_ROW2;
                        end
                        else if (digit == key_high_reg)
                        begin
                            pend_next = scc_pkg::PEND_ROW3;
                        end
                        else if (top_dec != scc_pkg::NO_ENTRY)
                        begin
                            res_n = 2'd1;
                            res0  = top_dec;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= scc_pkg::PEND_NONE;
        end
        else if (s1_take)
        begin
            pend_reg <= pend_next;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        out_cnt_next   = out_cnt_reg;
        out_d0_next    = out_d0_reg;
        out_last0_next = out_last0_reg;
        out_d1_next    = out_d1_reg;
        if (s1_take)
        begin
            // slot zero is free or leaving this cycle
            out_cnt_next   = res_n;
            out_d0_next    = res0;
            out_last0_next = (res_n == 2'd1);
            out_d1_next    = res1;
        end
        else if (out_fire)
        begin
            if (out_cnt_reg == 2'd2)
            begin
                out_cnt_next   = 2'd1;
                out_d0_next    = out_d1_reg;
                out_last0_next = 1'b1;
            end
            else
            begin
                out_cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d0_reg    <= out_d0_next;
        out_last0_reg <= out_last0_next;
        out_d1_reg    <= out_d1_next;
    end

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = out_d0_reg;
    assign m_tlast  = out_last0_reg;

    // ---------------- assertions ----------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("result count out of range");

    a_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg == 2'd2) |-> !out_last0_reg)
        else $error("first of a digit pair marked last");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |=> m_tvalid)
        else $error("second digit of a pair missing");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_take) |=> (s1_valid_reg && $stable(s1_char_reg)))
        else $error("stalled request lost");

    a_pend_code: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_take |=> $stable(pend_reg))
        else $error("prefix changed without a request");

endmodule
